/* rtl/ccsp_pkg.sv */
// ---------------------------------------------------------------------------
// CSS color string parser package
// Shared constants, mode codes and the color name ROM functions.
// ---------------------------------------------------------------------------
package ccsp_pkg;

	localparam int ROM_ENTRIES = 148;
	localparam int ROM_WIDTH   = 21;
	localparam int NAME_COUNT_DEF   = 148;
	localparam int NAME_MAX_LEN_DEF = 20;
	localparam int ALPHA_DIGITS_DEF = 3;

	localparam logic [2:0] M_PREFIX = 3'd0;
	localparam logic [2:0] M_HEX    = 3'd1;
	localparam logic [2:0] M_LEAD   = 3'd2;
	localparam logic [2:0] M_CHAN   = 3'd3;
	localparam logic [2:0] M_ALPHA  = 3'd4;
	localparam logic [2:0] M_FRAC   = 3'd5;
	localparam logic [2:0] M_DONE   = 3'd6;
	localparam logic [2:0] M_NAME   = 3'd7;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LG    = 8'h67;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	typedef logic [8*ROM_WIDTH-1:0] name_str_t;

	// Color names, left aligned, zero padded to the ROM width
	function automatic name_str_t name_str(input logic [7:0] idx);
		logic [8*ROM_WIDTH-1:0] s;
		begin
			unique case (idx)
				8'd0: s = "transparent";
				8'd1: s = "aliceblue";
				8'd2: s = "antiquewhite";
				8'd3: s = "aqua";
				8'd4: s = "aquamarine";
				8'd5: s = "azure";
				8'd6: s = "beige";
				8'd7: s = "bisque";
				8'd8: s = "black";
				8'd9: s = "blanchedalmond";
				8'd10: s = "blue";
				8'd11: s = "blueviolet";
				8'd12: s = "brown";
				8'd13: s = "burlywood";
				8'd14: s = "cadetblue";
				8'd15: s = "chartreuse";
				8'd16: s = "chocolate";
				8'd17: s = "coral";
				8'd18: s = "cornflowerblue";
				8'd19: s = "cornsilk";
				8'd20: s = "crimson";
				8'd21: s = "cyan";
				8'd22: s = "darkblue";
				8'd23: s = "darkcyan";
				8'd24: s = "darkgoldenrod";
				8'd25: s = "darkgray";
				8'd26: s = "darkgreen";
				8'd27: s = "darkgrey";
				8'd28: s = "darkkhaki";
				8'd29: s = "darkmagenta";
				8'd30: s = "darkolivegreen";
				8'd31: s = "darkorange";
				8'd32: s = "darkorchid";
				8'd33: s = "darkred";
				8'd34: s = "darksalmon";
				8'd35: s = "darkseagreen";
				8'd36: s = "darkslateblue";
				8'd37: s = "darkslategray";
				8'd38: s = "darkslategrey";
				8'd39: s = "darkturquoise";
				8'd40: s = "darkviolet";
				8'd41: s = "deeppink";
				8'd42: s = "deepskyblue";
				8'd43: s = "dimgray";
				8'd44: s = "dimgrey";
				8'd45: s = "dodgerblue";
				8'd46: s = "firebrick";
				8'd47: s = "floralwhite";
				8'd48: s = "forestgreen";
				8'd49: s = "fuchsia";
				8'd50: s = "gainsboro";
				8'd51: s = "ghostwhite";
				8'd52: s = "gold";
				8'd53: s = "goldenrod";
				8'd54: s = "gray";
				8'd55: s = "green";
				8'd56: s = "greenyellow";
				8'd57: s = "grey";
				8'd58: s = "honeydew";
				8'd59: s = "hotpink";
				8'd60: s = "indianred";
				8'd61: s = "indigo";
				8'd62: s = "ivory";
				8'd63: s = "khaki";
				8'd64: s = "lavender";
				8'd65: s = "lavenderblush";
				8'd66: s = "lawngreen";
				8'd67: s = "lemonchiffon";
				8'd68: s = "lightblue";
				8'd69: s = "lightcoral";
				8'd70: s = "lightcyan";
				8'd71: s = "lightgoldenrodyellow";
				8'd72: s = "lightgray";
				8'd73: s = "lightgreen";
				8'd74: s = "lightgrey";
				8'd75: s = "lightpink";
				8'd76: s = "lightsalmon";
				8'd77: s = "lightseagreen";
				8'd78: s = "lightskyblue";
				8'd79: s = "lightslategray";
				8'd80: s = "lightslategrey";
				8'd81: s = "lightsteelblue";
				8'd82: s = "lightyellow";
				8'd83: s = "lime";
				8'd84: s = "limegreen";
				8'd85: s = "linen";
				8'd86: s = "magenta";
				8'd87: s = "maroon";
				8'd88: s = "mediumaquamarine";
				8'd89: s = "mediumblue";
				8'd90: s = "mediumorchid";
				8'd91: s = "mediumpurple";
				8'd92: s = "mediumseagreen";
				8'd93: s = "mediumslateblue";
				8'd94: s = "mediumspringgreen";
				8'd95: s = "mediumturquoise";
				8'd96: s = "mediumvioletred";
				8'd97: s = "midnightblue";
				8'd98: s = "mintcream";
				8'd99: s = "mistyrose";
				8'd100: s = "moccasin";
				8'd101: s = "navajowhite";
				8'd102: s = "navy";
				8'd103: s = "oldlace";
				8'd104: s = "olive";
				8'd105: s = "olivedrab";
				8'd106: s = "orange";
				8'd107: s = "orangered";
				8'd108: s = "orchid";
				8'd109: s = "palegoldenrod";
				8'd110: s = "palegreen";
				8'd111: s = "paleturquoise";
				8'd112: s = "palevioletred";
				8'd113: s = "papayawhip";
				8'd114: s = "peachpuff";
				8'd115: s = "peru";
				8'd116: s = "pink";
				8'd117: s = "plum";
				8'd118: s = "powderblue";
				8'd119: s = "purple";
				8'd120: s = "red";
				8'd121: s = "rosybrown";
				8'd122: s = "royalblue";
				8'd123: s = "saddlebrown";
				8'd124: s = "salmon";
				8'd125: s = "sandybrown";
				8'd126: s = "seagreen";
				8'd127: s = "seashell";
				8'd128: s = "sienna";
				8'd129: s = "silver";
				8'd130: s = "skyblue";
				8'd131: s = "slateblue";
				8'd132: s = "slategray";
				8'd133: s = "slategrey";
				8'd134: s = "snow";
				8'd135: s = "springgreen";
				8'd136: s = "steelblue";
				8'd137: s = "tan";
				8'd138: s = "teal";
				8'd139: s = "thistle";
				8'd140: s = "tomato";
				8'd141: s = "turquoise";
				8'd142: s = "violet";
				8'd143: s = "wheat";
				8'd144: s = "white";
				8'd145: s = "whitesmoke";
				8'd146: s = "yellow";
				8'd147: s = "yellowgreen";
				default: s = '0;
			endcase
			// move the string from right aligned to left aligned
			while (s != '0 && s[8*ROM_WIDTH-1 -: 8] == 8'h00) s = s << 8;
			return s;
		end
	endfunction

	// Byte at a position of a name, zero past its end
	function automatic logic [7:0] name_char(input logic [7:0] idx, input logic [4:0] pos);
		name_str_t s;
		begin
			s = name_str(idx);
			if (32'(pos) >= ROM_WIDTH) return 8'h00;
			return s[8*ROM_WIDTH-1 - 8*int'(pos) -: 8];
		end
	endfunction

	// Name length
	function automatic logic [4:0] name_len(input logic [7:0] idx);
		name_str_t s;
		logic [4:0] n;
		begin
			s = name_str(idx);
			n = '0;
			for (int k = 0; k < ROM_WIDTH; k++) begin
				if (s[8*ROM_WIDTH-1 - 8*k -: 8] != 8'h00) n = 5'(k + 1);
			end
			return n;
		end
	endfunction

	// Packed color word of a name
	function automatic logic [31:0] name_word(input logic [7:0] idx);
		logic [31:0] w;
		begin
			unique case (idx)
				8'd0: w = 32'hFFFFFF00; 8'd1: w = 32'hF0F8FFFF; 8'd2: w = 32'hFAEBD7FF;
				8'd3: w = 32'h00FFFFFF; 8'd4: w = 32'h7FFFD4FF; 8'd5: w = 32'hF0FFFFFF;
				8'd6: w = 32'hF5F5DCFF; 8'd7: w = 32'hFFE4C4FF; 8'd8: w = 32'h000000FF;
				8'd9: w = 32'hFFEBCDFF; 8'd10: w = 32'h0000FFFF; 8'd11: w = 32'h8A2BE2FF;
				8'd12: w = 32'hA52A2AFF; 8'd13: w = 32'hDEB887FF; 8'd14: w = 32'h5F9EA0FF;
				8'd15: w = 32'h7FFF00FF; 8'd16: w = 32'hD2691EFF; 8'd17: w = 32'hFF7F50FF;
				8'd18: w = 32'h6495EDFF; 8'd19: w = 32'hFFF8DCFF; 8'd20: w = 32'hDC143CFF;
				8'd21: w = 32'h00FFFFFF; 8'd22: w = 32'h00008BFF; 8'd23: w = 32'h008B8BFF;
				8'd24: w = 32'hB8860BFF; 8'd25: w = 32'hA9A9A9FF; 8'd26: w = 32'h006400FF;
				8'd27: w = 32'hA9A9A9FF; 8'd28: w = 32'hBDB76BFF; 8'd29: w = 32'h8B008BFF;
				8'd30: w = 32'h556B2FFF; 8'd31: w = 32'hFF8C00FF; 8'd32: w = 32'h9932CCFF;
				8'd33: w = 32'h8B0000FF; 8'd34: w = 32'hE9967AFF; 8'd35: w = 32'h8FBC8FFF;
				8'd36: w = 32'h483D8BFF; 8'd37: w = 32'h2F4F4FFF; 8'd38: w = 32'h2F4F4FFF;
				8'd39: w = 32'h00CED1FF; 8'd40: w = 32'h9400D3FF; 8'd41: w = 32'hFF1493FF;
				8'd42: w = 32'h00BFFFFF; 8'd43: w = 32'h696969FF; 8'd44: w = 32'h696969FF;
				8'd45: w = 32'h1E90FFFF; 8'd46: w = 32'hB22222FF; 8'd47: w = 32'hFFFAF0FF;
				8'd48: w = 32'h228B22FF; 8'd49: w = 32'hFF00FFFF; 8'd50: w = 32'hDCDCDCFF;
				8'd51: w = 32'hF8F8FFFF; 8'd52: w = 32'hFFD700FF; 8'd53: w = 32'hDAA520FF;
				8'd54: w = 32'h808080FF; 8'd55: w = 32'h008000FF; 8'd56: w = 32'hADFF2FFF;
				8'd57: w = 32'h808080FF; 8'd58: w = 32'hF0FFF0FF; 8'd59: w = 32'hFF69B4FF;
				8'd60: w = 32'hCD5C5CFF; 8'd61: w = 32'h4B0082FF; 8'd62: w = 32'hFFFFF0FF;
				8'd63: w = 32'hF0E68CFF; 8'd64: w = 32'hE6E6FAFF; 8'd65: w = 32'hFFF0F5FF;
				8'd66: w = 32'h7CFC00FF; 8'd67: w = 32'hFFFACDFF; 8'd68: w = 32'hADD8E6FF;
				8'd69: w = 32'hF08080FF; 8'd70: w = 32'hE0FFFFFF; 8'd71: w = 32'hFAFAD2FF;
				8'd72: w = 32'hD3D3D3FF; 8'd73: w = 32'h90EE90FF; 8'd74: w = 32'hD3D3D3FF;
				8'd75: w = 32'hFFB6C1FF; 8'd76: w = 32'hFFA07AFF; 8'd77: w = 32'h20B2AAFF;
				8'd78: w = 32'h87CEFAFF; 8'd79: w = 32'h778899FF; 8'd80: w = 32'h778899FF;
				8'd81: w = 32'hB0C4DEFF; 8'd82: w = 32'hFFFFE0FF; 8'd83: w = 32'h00FF00FF;
				8'd84: w = 32'h32CD32FF; 8'd85: w = 32'hFAF0E6FF; 8'd86: w = 32'hFF00FFFF;
				8'd87: w = 32'h800000FF; 8'd88: w = 32'h66CDAAFF; 8'd89: w = 32'h0000CDFF;
				8'd90: w = 32'hBA55D3FF; 8'd91: w = 32'h9370DBFF; 8'd92: w = 32'h3CB371FF;
				8'd93: w = 32'h7B68EEFF; 8'd94: w = 32'h00FA9AFF; 8'd95: w = 32'h48D1CCFF;
				8'd96: w = 32'hC71585FF; 8'd97: w = 32'h191970FF; 8'd98: w = 32'hF5FFFAFF;
				8'd99: w = 32'hFFE4E1FF; 8'd100: w = 32'hFFE4B5FF; 8'd101: w = 32'hFFDEADFF;
				8'd102: w = 32'h000080FF; 8'd103: w = 32'hFDF5E6FF; 8'd104: w = 32'h808000FF;
				8'd105: w = 32'h6B8E23FF; 8'd106: w = 32'hFFA500FF; 8'd107: w = 32'hFF4500FF;
				8'd108: w = 32'hDA70D6FF; 8'd109: w = 32'hEEE8AAFF; 8'd110: w = 32'h98FB98FF;
				8'd111: w = 32'hAFEEEEFF; 8'd112: w = 32'hDB7093FF; 8'd113: w = 32'hFFEFD5FF;
				8'd114: w = 32'hFFDAB9FF; 8'd115: w = 32'hCD853FFF; 8'd116: w = 32'hFFC0CBFF;
				8'd117: w = 32'hDDA0DDFF; 8'd118: w = 32'hB0E0E6FF; 8'd119: w = 32'h800080FF;
				8'd120: w = 32'hFF0000FF; 8'd121: w = 32'hBC8F8FFF; 8'd122: w = 32'h4169E1FF;
				8'd123: w = 32'h8B4513FF; 8'd124: w = 32'hFA8072FF; 8'd125: w = 32'hF4A460FF;
				8'd126: w = 32'h2E8B57FF; 8'd127: w = 32'hFFF5EEFF; 8'd128: w = 32'hA0522DFF;
				8'd129: w = 32'hC0C0C0FF; 8'd130: w = 32'h87CEEBFF; 8'd131: w = 32'h6A5ACDFF;
				8'd132: w = 32'h708090FF; 8'd133: w = 32'h708090FF; 8'd134: w = 32'hFFFAFAFF;
				8'd135: w = 32'h00FF7FFF; 8'd136: w = 32'h4682B4FF; 8'd137: w = 32'hD2B48CFF;
				8'd138: w = 32'h008080FF; 8'd139: w = 32'hD8BFD8FF; 8'd140: w = 32'hFF6347FF;
				8'd141: w = 32'h40E0D0FF; 8'd142: w = 32'hEE82EEFF; 8'd143: w = 32'hF5DEB3FF;
				8'd144: w = 32'hFFFFFFFF; 8'd145: w = 32'hF5F5F5FF; 8'd146: w = 32'hFFFF00FF;
				8'd147: w = 32'h9ACD32FF;
				default: w = '0;
			endcase
			return w;
		end
	endfunction

	// Power of ten as an elaboration constant
	function automatic int pow10(input int n);
		int s;
		begin
			s = 1;
			for (int k = 0; k < n; k++) s = s * 10;
			return s;
		end
	endfunction

endpackage

/* rtl/ccsp_stream_if.sv */
// ---------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one request payload of parameterized width between two modules.
// ---------------------------------------------------------------------------
interface ccsp_stream_if #(
	parameter int W = 9
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/css_color_string_parser.sv */
// ---------------------------------------------------------------------------
// CSS color string parser
// Streams a color string in byte by byte and returns one packed RGBA word.
// ---------------------------------------------------------------------------
// One byte is taken per cycle when the output is free; each byte goes through
// the character decode and the parallel name compare combinationally, and the
// result of the last byte is loaded into an output register as it is taken. A new
// string may follow at once. The input request carries {last_char, char_code}
// and the output request carries {valid_res, color_word}.
module css_color_string_parser
	import ccsp_pkg::*;
#(
	parameter int NAME_COUNT   = NAME_COUNT_DEF,
	parameter int NAME_MAX_LEN = NAME_MAX_LEN_DEF,
	parameter int ALPHA_DIGITS = ALPHA_DIGITS_DEF
) (
	input logic clk,
	input logic arst_n,
	ccsp_stream_if.sink   in_ch,
	ccsp_stream_if.source out_ch
);

	localparam int NUSED  = (NAME_COUNT < ROM_ENTRIES) ? NAME_COUNT : ROM_ENTRIES;
	localparam int ASCALE = pow10(ALPHA_DIGITS);
	localparam int AFW    = $clog2(ASCALE + 1);
	localparam int ADW    = $clog2(ALPHA_DIGITS + 1);
	localparam int PW     = AFW + 9;
	localparam int RSH    = PW + AFW;
	localparam longint RMUL = ((longint'(1) << RSH) + longint'(ASCALE) - longint'(1)) /
		longint'(ASCALE);

	logic [7:0] c;
	logic       last;
	logic       acc;

	logic [2:0]       mode_q;
	logic [4:0]       cnt_q;
	logic [23:0]      hex_q;
	logic [7:0]       chv_q;
	logic [1:0]       chi_q;
	logic             chd_q;
	logic [7:0]       red_q, grn_q, blu_q;
	logic [AFW-1:0]   af_q;
	logic [ADW-1:0]   adc_q;
	logic             wa_q;
	logic             fail_q;
	logic [NUSED-1:0] alive_q;

	logic [2:0]       mode_d;
	logic [23:0]      hex_d;
	logic [7:0]       chv_d;
	logic [1:0]       chi_d;
	logic             chd_d;
	logic [7:0]       red_d, grn_d, blu_d;
	logic [AFW-1:0]   af_d;
	logic [ADW-1:0]   adc_d;
	logic             wa_d;
	logic             fail_d;
	logic [NUSED-1:0] alive_d;
	logic [4:0]       cnt_d;

	logic        out_v_q;
	logic [31:0] word_q;
	logic        ok_q;
	logic [31:0] word_d;
	logic        ok_d;

	assign c     = in_ch.data[7:0];
	assign last  = in_ch.data[8];
	assign in_ch.ready = !out_v_q || out_ch.ready;
	assign acc   = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = {ok_q, word_q};

	function automatic logic is_dec(input logic [7:0] x);
		return x >= CH_0 && x <= CH_9;
	endfunction

	function automatic logic is_sep(input logic [7:0] x);
		return x == CH_SPACE || x == CH_COMMA;
	endfunction

	function automatic logic [3:0] hexv(input logic [7:0] x);
		logic [3:0] v;
		begin
			if (is_dec(x)) v = 4'(x - CH_0);
			else if (x >= CH_LA && x <= CH_LF) v = 4'(x - CH_LA + 8'd10);
			else if (x >= CH_UA && x <= CH_UF) v = 4'(x - CH_UA + 8'd10);
			else v = 4'd0;
			return v;
		end
	endfunction

	// Narrow names still matching at this byte position
	always_comb begin
		for (int i = 0; i < NUSED; i++) begin
			alive_d[i] = alive_q[i] && (32'(cnt_q) < NAME_MAX_LEN) &&
				(32'(cnt_q) < ROM_WIDTH - 1) && c != 8'h00 &&
				name_char(8'(i), cnt_q) == c;
		end
	end

	// Advance the parse state by one byte
	always_comb begin
		logic [3:0] dv;
		logic [11:0] mul;
		logic [7:0] nv;
		logic [AFW+3:0] fnext;
		logic [AFW+11:0] fs;
		logic [31:0] tmp;
		logic [ADW-1:0] n;
		logic [15:0] len;
		logic hit;
		logic [31:0] nw;
		logic [7:0] a;
		logic [AFW+8:0] prod;
		logic [2*PW+1:0] qp;
		logic [3:0] r4, g4, b4;
		logic [4:0] pn;

		mode_d = mode_q; hex_d = hex_q; chv_d = chv_q; chi_d = chi_q; chd_d = chd_q;
		red_d = red_q; grn_d = grn_q; blu_d = blu_q; af_d = af_q; adc_d = adc_q;
		wa_d = wa_q; fail_d = fail_q;
		dv = 4'(c - CH_0);
		mul = 12'(chv_q) * 12'd10 + 12'(dv);
		nv = (mul > 12'd255) ? 8'd255 : mul[7:0];
		fnext = (AFW+4)'(af_q) * (AFW+4)'(10) + (AFW+4)'(dv);

		if (!fail_q) begin
			unique case (mode_q)
				M_PREFIX: begin
					if (cnt_q == 5'd0) begin
						if (c == CH_HASH) mode_d = M_HEX;
						else if (c != CH_LR) mode_d = M_NAME;
					end else if (cnt_q == 5'd1) begin
						if (c != CH_LG) mode_d = M_NAME;
					end else if (cnt_q == 5'd2) begin
						if (c != CH_LB) mode_d = M_NAME;
					end else if (cnt_q == 5'd3 && c == CH_LA) begin
						wa_d = 1'b1;
					end else if (c == CH_LPAR && (cnt_q == 5'd3 || wa_q)) begin
						mode_d = M_LEAD;
					end else begin
						fail_d = 1'b1;
					end
				end
				M_HEX: hex_d = {hex_q[19:0], hexv(c)};
				M_LEAD: begin
					if (is_dec(c)) begin
						mode_d = M_CHAN; chd_d = 1'b1; chv_d = 8'(dv);
					end else if (c != CH_SPACE) begin
						fail_d = 1'b1;
					end
				end
				M_CHAN: begin
					if (is_dec(c)) begin
						chd_d = 1'b1;
						chv_d = chd_q ? nv : 8'(dv);
					end else if (chd_q && (is_sep(c) || chi_q == 2'd2)) begin
						// commit the finished channel
						if (chi_q == 2'd0) red_d = chv_q;
						else if (chi_q == 2'd1) grn_d = chv_q;
						else blu_d = chv_q;
						chv_d = '0; chd_d = 1'b0;
						if (chi_q != 2'd2) chi_d = chi_q + 2'd1;
						else if (!wa_q) mode_d = M_DONE;
						else begin
							// alpha lead with no digit yet
							mode_d = M_ALPHA;
							if (is_sep(c)) mode_d = M_ALPHA;
							else if (c >= CH_1 && c <= CH_9) begin
								af_d = AFW'(ASCALE); adc_d = ADW'(ALPHA_DIGITS);
								mode_d = M_DONE;
							end else if (c == CH_0) chd_d = 1'b1;
							else if (c == CH_DOT) mode_d = M_FRAC;
							else mode_d = M_DONE;
						end
					end else if (!(is_sep(c) && !chd_q)) begin
						fail_d = 1'b1;
					end
				end
				M_ALPHA: begin
					if (!chd_q) begin
						if (is_sep(c)) mode_d = M_ALPHA;
						else if (c >= CH_1 && c <= CH_9) begin
							af_d = AFW'(ASCALE); adc_d = ADW'(ALPHA_DIGITS);
							mode_d = M_DONE;
						end else if (c == CH_0) chd_d = 1'b1;
						else if (c == CH_DOT) mode_d = M_FRAC;
						else mode_d = M_DONE;
					end else begin
						mode_d = (c == CH_DOT) ? M_FRAC : M_DONE;
					end
				end
				M_FRAC: begin
					if (is_dec(c)) begin
						if (32'(adc_q) < ALPHA_DIGITS) begin
							af_d = AFW'(fnext); adc_d = adc_q + ADW'(1);
						end
					end else begin
						mode_d = M_DONE;
					end
				end
				default: ;
			endcase
		end
		cnt_d = (cnt_q < 5'd31) ? cnt_q + 5'd1 : 5'd31;

		// Result of the final byte
		word_d = '0; ok_d = 1'b0;
		hit = 1'b0; nw = '0;
		pn = cnt_q + 5'd1;
		for (int i = NUSED - 1; i >= 0; i--) begin
			if (alive_d[i] && name_len(8'(i)) == pn && 32'(pn) < ROM_WIDTH) begin
				hit = 1'b1; nw = name_word(8'(i));
			end
		end
		// scale kept alpha digits to the full fraction width
		fs = (AFW+12)'(af_d);
		n = adc_d;
		for (int k = 0; k < ALPHA_DIGITS; k++) begin
			if (32'(n) < ALPHA_DIGITS) begin
				fs = fs * (AFW+12)'(10); n = n + ADW'(1);
			end
		end
		prod = (AFW+9)'(fs) * (AFW+9)'(255);
		// divide by the alpha scale through a reciprocal multiply
		qp = (2*PW+2)'(prod) * (2*PW+2)'(RMUL);
		tmp = 32'(qp >> RSH);
		a = wa_d ? tmp[7:0] : 8'd255;
		len = 16'(cnt_d) - 16'd1;
		r4 = hex_d[11:8]; g4 = hex_d[7:4]; b4 = hex_d[3:0];
		if (!fail_d) begin
			if (mode_d == M_HEX) begin
				if (len == 16'd6) begin
					word_d = {hex_d, 8'hFF}; ok_d = 1'b1;
				end else if (len == 16'd3) begin
					word_d = {r4, r4, g4, g4, b4, b4, 8'hFF}; ok_d = 1'b1;
				end
			end else if (mode_d == M_NAME || (mode_d == M_PREFIX && cnt_d < 5'd3)) begin
				word_d = nw; ok_d = hit;
			end else if (mode_d == M_CHAN) begin
				if (chd_d && chi_d == 2'd2) begin
					word_d = {red_d, grn_d, chv_d, a}; ok_d = 1'b1;
				end
			end else if (mode_d == M_ALPHA || mode_d == M_FRAC || mode_d == M_DONE) begin
				word_d = {red_d, grn_d, blu_d, a}; ok_d = 1'b1;
			end
		end
		if (!ok_d) word_d = '0;
	end

	// Hold or advance the parse state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PREFIX; cnt_q <= '0; hex_q <= '0; chv_q <= '0; chi_q <= '0;
			chd_q <= 1'b0; red_q <= '0; grn_q <= '0; blu_q <= '0; af_q <= '0;
			adc_q <= '0; wa_q <= 1'b0; fail_q <= 1'b0; alive_q <= '1;
		end else if (acc) begin
			if (last) begin
				mode_q <= M_PREFIX; cnt_q <= '0; hex_q <= '0; chv_q <= '0; chi_q <= '0;
				chd_q <= 1'b0; red_q <= '0; grn_q <= '0; blu_q <= '0; af_q <= '0;
				adc_q <= '0; wa_q <= 1'b0; fail_q <= 1'b0; alive_q <= '1;
			end else begin
				mode_q <= mode_d; cnt_q <= cnt_d; hex_q <= hex_d; chv_q <= chv_d;
				chi_q <= chi_d; chd_q <= chd_d; red_q <= red_d; grn_q <= grn_d;
				blu_q <= blu_d; af_q <= af_d; adc_q <= adc_d; wa_q <= wa_d;
				fail_q <= fail_d; alive_q <= alive_d;
			end
		end
	end

	// Load the output register on the final byte, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (acc && last) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last) begin
			word_q <= word_d;
			ok_q   <= ok_d;
		end
	end

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// CSS color string parser testbench
// Streams color strings into the parser one byte per request and checks each
// returned RGBA word against a testbench parser model or a directed row's value.
// ---------------------------------------------------------------------------
module tb
	import ccsp_pkg::*;
();

	localparam int NAME_LIMIT  = 20;
	localparam int ALPHA_SCALE = 1000;
	localparam int RAND_ITEMS  = 1200;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [7:0]  c;
		logic        last;
		bit          typed;
		logic [31:0] w;
		logic        v;
	} char_req_t;

	typedef struct {
		string       s;
		int          pos;
		logic [7:0]  subst;
		bit          typed;
		logic [31:0] w;
		logic        v;
	} dir_row_t;

	typedef struct {
		logic [31:0] w;
		logic        v;
	} color_t;

	logic clk;
	logic arst_n;

	ccsp_stream_if #(.W(9))  in_ch ();
	ccsp_stream_if #(.W(33)) out_ch ();

	css_color_string_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	string color_names [148] = '{
		"transparent","aliceblue","antiquewhite","aqua","aquamarine","azure","beige",
		"bisque","black","blanchedalmond","blue","blueviolet","brown","burlywood",
		"cadetblue","chartreuse","chocolate","coral","cornflowerblue","cornsilk",
		"crimson","cyan","darkblue","darkcyan","darkgoldenrod","darkgray","darkgreen",
		"darkgrey","darkkhaki","darkmagenta","darkolivegreen","darkorange",
		"darkorchid","darkred","darksalmon","darkseagreen","darkslateblue",
		"darkslategray","darkslategrey","darkturquoise","darkviolet","deeppink",
		"deepskyblue","dimgray","dimgrey","dodgerblue","firebrick","floralwhite",
		"forestgreen","fuchsia","gainsboro","ghostwhite","gold","goldenrod","gray",
		"green","greenyellow","grey","honeydew","hotpink","indianred","indigo",
		"ivory","khaki","lavender","lavenderblush","lawngreen","lemonchiffon",
		"lightblue","lightcoral","lightcyan","lightgoldenrodyellow","lightgray",
		"lightgreen","lightgrey","lightpink","lightsalmon","lightseagreen",
		"lightskyblue","lightslategray","lightslategrey","lightsteelblue",
		"lightyellow","lime","limegreen","linen","magenta","maroon",
		"mediumaquamarine","mediumblue","mediumorchid","mediumpurple",
		"mediumseagreen","mediumslateblue","mediumspringgreen","mediumturquoise",
		"mediumvioletred","midnightblue","mintcream","mistyrose","moccasin",
		"navajowhite","navy","oldlace","olive","olivedrab","orange","orangered",
		"orchid","palegoldenrod","palegreen","paleturquoise","palevioletred",
		"papayawhip","peachpuff","peru","pink","plum","powderblue","purple","red",
		"rosybrown","royalblue","saddlebrown","salmon","sandybrown","seagreen",
		"seashell","sienna","silver","skyblue","slateblue","slategray","slategrey",
		"snow","springgreen","steelblue","tan","teal","thistle","tomato","turquoise",
		"violet","wheat","white","whitesmoke","yellow","yellowgreen"
	};

	logic [31:0] color_words [148] = '{
		32'hFFFFFF00,32'hF0F8FFFF,32'hFAEBD7FF,32'h00FFFFFF,32'h7FFFD4FF,32'hF0FFFFFF,
		32'hF5F5DCFF,32'hFFE4C4FF,32'h000000FF,32'hFFEBCDFF,32'h0000FFFF,32'h8A2BE2FF,
		32'hA52A2AFF,32'hDEB887FF,32'h5F9EA0FF,32'h7FFF00FF,32'hD2691EFF,32'hFF7F50FF,
		32'h6495EDFF,32'hFFF8DCFF,32'hDC143CFF,32'h00FFFFFF,32'h00008BFF,32'h008B8BFF,
		32'hB8860BFF,32'hA9A9A9FF,32'h006400FF,32'hA9A9A9FF,32'hBDB76BFF,32'h8B008BFF,
		32'h556B2FFF,32'hFF8C00FF,32'h9932CCFF,32'h8B0000FF,32'hE9967AFF,32'h8FBC8FFF,
		32'h483D8BFF,32'h2F4F4FFF,32'h2F4F4FFF,32'h00CED1FF,32'h9400D3FF,32'hFF1493FF,
		32'h00BFFFFF,32'h696969FF,32'h696969FF,32'h1E90FFFF,32'hB22222FF,32'hFFFAF0FF,
		32'h228B22FF,32'hFF00FFFF,32'hDCDCDCFF,32'hF8F8FFFF,32'hFFD700FF,32'hDAA520FF,
		32'h808080FF,32'h008000FF,32'hADFF2FFF,32'h808080FF,32'hF0FFF0FF,32'hFF69B4FF,
		32'hCD5C5CFF,32'h4B0082FF,32'hFFFFF0FF,32'hF0E68CFF,32'hE6E6FAFF,32'hFFF0F5FF,
		32'h7CFC00FF,32'hFFFACDFF,32'hADD8E6FF,32'hF08080FF,32'hE0FFFFFF,32'hFAFAD2FF,
		32'hD3D3D3FF,32'h90EE90FF,32'hD3D3D3FF,32'hFFB6C1FF,32'hFFA07AFF,32'h20B2AAFF,
		32'h87CEFAFF,32'h778899FF,32'h778899FF,32'hB0C4DEFF,32'hFFFFE0FF,32'h00FF00FF,
		32'h32CD32FF,32'hFAF0E6FF,32'hFF00FFFF,32'h800000FF,32'h66CDAAFF,32'h0000CDFF,
		32'hBA55D3FF,32'h9370DBFF,32'h3CB371FF,32'h7B68EEFF,32'h00FA9AFF,32'h48D1CCFF,
		32'hC71585FF,32'h191970FF,32'hF5FFFAFF,32'hFFE4E1FF,32'hFFE4B5FF,32'hFFDEADFF,
		32'h000080FF,32'hFDF5E6FF,32'h808000FF,32'h6B8E23FF,32'hFFA500FF,32'hFF4500FF,
		32'hDA70D6FF,32'hEEE8AAFF,32'h98FB98FF,32'hAFEEEEFF,32'hDB7093FF,32'hFFEFD5FF,
		32'hFFDAB9FF,32'hCD853FFF,32'hFFC0CBFF,32'hDDA0DDFF,32'hB0E0E6FF,32'h800080FF,
		32'hFF0000FF,32'hBC8F8FFF,32'h4169E1FF,32'h8B4513FF,32'hFA8072FF,32'hF4A460FF,
		32'h2E8B57FF,32'hFFF5EEFF,32'hA0522DFF,32'hC0C0C0FF,32'h87CEEBFF,32'h6A5ACDFF,
		32'h708090FF,32'h708090FF,32'hFFFAFAFF,32'h00FF7FFF,32'h4682B4FF,32'hD2B48CFF,
		32'h008080FF,32'hD8BFD8FF,32'hFF6347FF,32'h40E0D0FF,32'hEE82EEFF,32'hF5DEB3FF,
		32'hFFFFFFFF,32'hF5F5F5FF,32'hFFFF00FF,32'h9ACD32FF
	};

	// Parser state mirrored in the testbench
	logic [2:0]  pmode;
	logic [4:0]  nchars;
	logic [23:0] hex_acc;
	logic [7:0]  chan_val;
	logic [1:0]  chan_idx;
	logic        chan_dig;
	logic [7:0]  red_v, grn_v, blu_v;
	logic [9:0]  frac_v;
	logic [1:0]  frac_cnt;
	logic        is_rgba;
	logic        bad;
	logic [7:0]  name_buf [$];

	char_req_t char_reqs [$];
	color_t    expected_colors [$];
	int        err_cnt;
	int        colors_seen;
	int        idle_cycles;

	function automatic bit is_dec(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_sep(input logic [7:0] c);
		return c == CH_SPACE || c == CH_COMMA;
	endfunction

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		if (is_dec(c)) return 4'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 10);
		if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 10);
		return 4'd0;
	endfunction

	task automatic clear_parse();
		pmode = M_PREFIX;
		nchars = '0;
		hex_acc = '0;
		chan_val = '0;
		chan_idx = '0;
		chan_dig = 1'b0;
		red_v = '0;
		grn_v = '0;
		blu_v = '0;
		frac_v = '0;
		frac_cnt = '0;
		is_rgba = 1'b0;
		bad = 1'b0;
		name_buf.delete();
	endtask

	task automatic store_channel();
		case (chan_idx)
			2'd0: red_v = chan_val;
			2'd1: grn_v = chan_val;
			default: blu_v = chan_val;
		endcase
		chan_val = '0;
		chan_dig = 1'b0;
	endtask

	task automatic alpha_byte(input logic [7:0] c);
		if (pmode == M_ALPHA) begin
			if (!chan_dig) begin
				if (is_sep(c)) return;
				if (c >= CH_1 && c <= CH_9) begin
					frac_v = 10'(ALPHA_SCALE);
					frac_cnt = 2'd3;
					pmode = M_DONE;
				end else if (c == CH_0) begin
					chan_dig = 1'b1;
				end else if (c == CH_DOT) begin
					pmode = M_FRAC;
				end else begin
					pmode = M_DONE;
				end
			end else begin
				pmode = (c == CH_DOT) ? M_FRAC : M_DONE;
			end
		end else if (pmode == M_FRAC) begin
			if (is_dec(c)) begin
				if (frac_cnt < 2'd3) begin
					frac_v = 10'(frac_v * 10 + (c - CH_0));
					frac_cnt++;
				end
			end else begin
				pmode = M_DONE;
			end
		end
	endtask

	task automatic channel_byte(input logic [7:0] c);
		int acc;
		bit was_blue;
		if (is_dec(c)) begin
			if (chan_dig) begin
				acc = chan_val * 10 + (c - CH_0);
				chan_val = (acc > 255) ? 8'd255 : 8'(acc);
			end else begin
				chan_dig = 1'b1;
				chan_val = 8'(c - CH_0);
			end
		end else if (chan_dig && (is_sep(c) || chan_idx == 2'd2)) begin
			was_blue = chan_idx == 2'd2;
			store_channel();
			if (!was_blue) begin
				chan_idx++;
			end else if (is_rgba) begin
				pmode = M_ALPHA;
				alpha_byte(c);
			end else begin
				pmode = M_DONE;
			end
		end else if (!(is_sep(c) && !chan_dig)) begin
			bad = 1'b1;
		end
	endtask

	task automatic prefix_byte(input logic [7:0] c, input logic [4:0] p);
		if (p == 0) begin
			if (c == CH_HASH) pmode = M_HEX;
			else if (c != CH_LR) pmode = M_NAME;
		end else if (p == 1) begin
			if (c != CH_LG) pmode = M_NAME;
		end else if (p == 2) begin
			if (c != CH_LB) pmode = M_NAME;
		end else if (p == 3 && c == CH_LA) begin
			is_rgba = 1'b1;
		end else if (c == CH_LPAR && (p == 3 || is_rgba)) begin
			pmode = M_LEAD;
		end else begin
			bad = 1'b1;
		end
	endtask

	// Exact, case-sensitive match of the whole string against the name table
	function automatic bit lookup_name(output logic [31:0] w);
		bit same;
		w = '0;
		if (name_buf.size() > NAME_LIMIT) return 1'b0;
		foreach (color_names[i]) begin
			if (color_names[i].len() == name_buf.size()) begin
				same = 1'b1;
				foreach (name_buf[k]) if (name_buf[k] != color_names[i][k]) same = 1'b0;
				if (same) begin
					w = color_words[i];
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Advance the parser by one byte; on the last byte produce the color
	task automatic parse_color_byte(input logic [7:0] c, input logic last,
			output bit has, output color_t res);
		logic [4:0]  p;
		logic [2:0]  m;
		logic [7:0]  a;
		int          f;
		int          n;
		bit          hit;
		has = 1'b0;
		res.w = '0;
		res.v = 1'b0;
		p = nchars;
		name_buf.push_back(c);
		if (!bad) begin
			case (pmode)
				M_PREFIX: prefix_byte(c, p);
				M_HEX: hex_acc = {hex_acc[19:0], hex_digit(c)};
				M_LEAD: begin
					if (is_dec(c)) begin
						pmode = M_CHAN;
						chan_dig = 1'b1;
						chan_val = 8'(c - CH_0);
					end else if (c != CH_SPACE) begin
						bad = 1'b1;
					end
				end
				M_CHAN: channel_byte(c);
				M_ALPHA, M_FRAC: alpha_byte(c);
				default: ;
			endcase
		end
		nchars = (p < 5'd31) ? p + 5'd1 : 5'd31;
		if (!last) return;
		has = 1'b1;
		if (!bad) begin
			m = pmode;
			if (m == M_HEX) begin
				if (nchars - 1 == 6) begin
					res.w = {hex_acc, 8'hFF};
					res.v = 1'b1;
				end else if (nchars - 1 == 3) begin
					res.w = {{2{hex_acc[11:8]}}, {2{hex_acc[7:4]}}, {2{hex_acc[3:0]}}, 8'hFF};
					res.v = 1'b1;
				end
			end else if (m == M_NAME || (m == M_PREFIX && nchars < 3)) begin
				hit = lookup_name(res.w);
				res.v = hit;
			end else if (m == M_CHAN) begin
				if (chan_dig && chan_idx == 2'd2) begin
					store_channel();
					res.v = 1'b1;
				end
			end else if (m inside {M_ALPHA, M_FRAC, M_DONE}) begin
				res.v = 1'b1;
			end
			if (res.v && m != M_HEX && m != M_NAME && m != M_PREFIX) begin
				if (is_rgba) begin
					f = frac_v;
					for (n = frac_cnt; n < 3; n++) f = f * 10;
					a = 8'(f * 255 / ALPHA_SCALE);
				end else begin
					a = 8'hFF;
				end
				res.w = {red_v, grn_v, blu_v, a};
			end
		end
		if (!res.v) res.w = '0;
		clear_parse();
	endtask

	task automatic queue_string(input logic [7:0] s [$], input bit typed,
			input logic [31:0] w, input logic v);
		char_req_t r;
		foreach (s[k]) begin
			r.c = s[k];
			r.last = (k == s.size() - 1);
			r.typed = typed && r.last;
			r.w = w;
			r.v = v;
			char_reqs.push_back(r);
		end
	endtask

	task automatic push_text(inout logic [7:0] s [$], input string t);
		for (int k = 0; k < t.len(); k++) s.push_back(t[k]);
	endtask

	// Separator run between channels: spaces and commas, sometimes missing
	task automatic push_seps(inout logic [7:0] s [$]);
		int n;
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		repeat (n) s.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COMMA);
	endtask

	task automatic build_random_string(output logic [7:0] s [$]);
		string digits;
		int    n;
		int    kind;
		s.delete();
		digits = "0123456789abcdefABCDEF";
		kind = $urandom_range(0, 9);
		if (kind <= 1) begin
			// hex form, mostly legal lengths
			s.push_back(CH_HASH);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) :
				($urandom_range(0, 1) ? 3 : 6);
			repeat (n) s.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) :
				digits[$urandom_range(0, digits.len() - 1)]);
		end else if (kind <= 5) begin
			// functional form with decimal channels and optional alpha
			push_text(s, $urandom_range(0, 1) ? "rgba(" : "rgb(");
			repeat ($urandom_range(0, 2)) s.push_back(CH_SPACE);
			for (int ch = 0; ch < 3; ch++) begin
				if ($urandom_range(0, 29) != 0)
					push_text(s, $sformatf("%0d", ($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 999) : $urandom_range(0, 255)));
				if (ch < 2) push_seps(s);
			end
			case ($urandom_range(0, 5))
				0: ;
				1: begin
					push_seps(s);
					s.push_back(8'($urandom_range(CH_1, CH_9)));
				end
				2, 3: begin
					push_seps(s);
					if ($urandom_range(0, 1)) s.push_back(CH_0);
					s.push_back(CH_DOT);
					repeat ($urandom_range(0, 5)) s.push_back(8'($urandom_range(CH_0, CH_9)));
				end
				4: begin
					push_seps(s);
					s.push_back(CH_0);
				end
				default: push_seps(s);
			endcase
			if ($urandom_range(0, 1)) s.push_back(8'h29);
			repeat ($urandom_range(0, 2)) s.push_back(8'($urandom));
		end else if (kind <= 7) begin
			// color name, sometimes bent out of shape
			push_text(s, color_names[$urandom_range(0, 147)]);
			case ($urandom_range(0, 5))
				0: s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
				1: s.push_back(8'($urandom_range(8'h61, 8'h7A)));
				2: if (s.size() > 1) void'(s.pop_back());
				3: s[0] = s[0] - 8'h20;
				default: ;
			endcase
		end else begin
			// raw noise, sometimes past the length counter
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
			repeat (n) s.push_back(8'($urandom));
		end
		// break a well-formed string now and then
		if ($urandom_range(0, 14) == 0) s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		err_cnt++;
	endtask

	// Check results and watch for a stalled run
	always @(posedge clk) begin
		color_t e;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				colors_seen <= colors_seen + 1;
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected color", out_ch.data[31:0], '0);
				end else begin
					e = expected_colors.pop_front();
					if (out_ch.data[31:0] !== e.w)
						report_mismatch("color_word", out_ch.data[31:0], e.w);
					if (out_ch.data[32] !== e.v)
						report_mismatch("valid_res", 32'(out_ch.data[32]), 32'(e.v));
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Output side: switch between stall patterns; one long hold-off
	initial begin
		int  pattern;
		int  tick;
		bit  held;
		out_ch.ready = 1'b0;
		pattern = 0;
		tick = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 64 == 0) pattern = $urandom_range(0, 3);
			if (!held && colors_seen >= 30) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case (pattern)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= (tick % 4 == 0);
				default: out_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Main sequence: reset, directed strings, random strings, drain
	initial begin
		dir_row_t    rows [$];
		logic [7:0]  s [$];
		char_req_t   r;
		color_t      res;
		bit          has;
		int          burst;
		err_cnt = 0;
		colors_seen = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		clear_parse();

		rows = '{
			'{"#fff", -1, 8'h00, 1, 32'hFFFFFFFF, 1},
			'{"#000000", -1, 8'h00, 1, 32'h000000FF, 1},
			'{"#AbC", -1, 8'h00, 1, 32'hAABBCCFF, 1},
			'{"#zz9", -1, 8'h00, 1, 32'h000099FF, 1},
			'{"#12345", -1, 8'h00, 1, 32'h0, 0},
			'{"#", -1, 8'h00, 1, 32'h0, 0},
			'{"#0x0", 2, 8'h00, 1, 32'h000000FF, 1},
			'{"rgb(255,0,10)", -1, 8'h00, 1, 32'hFF000AFF, 1},
			'{"rgb(  300 , 1,2)", -1, 8'h00, 1, 32'hFF0102FF, 1},
			'{"rgb(1 2 3)trailing", -1, 8'h00, 1, 32'h010203FF, 1},
			'{"rgb(1,2,3", -1, 8'h00, 0, 32'h0, 0},
			'{"rgb(1,2,)", -1, 8'h00, 1, 32'h0, 0},
			'{"rgb(a", -1, 8'h00, 1, 32'h0, 0},
			'{"rgbx", -1, 8'h00, 1, 32'h0, 0},
			'{"rg", -1, 8'h00, 1, 32'h0, 0},
			'{"rgba(1,2,3,0.5)", -1, 8'h00, 1, 32'h0102037F, 1},
			'{"rgba(1,2,3,.2509)", -1, 8'h00, 1, 32'h0102033F, 1},
			'{"rgba(1,2,3,7)", -1, 8'h00, 1, 32'h010203FF, 1},
			'{"rgba(1,2,3)", -1, 8'h00, 0, 32'h0, 0},
			'{"rgba(1,2,3 0x", -1, 8'h00, 0, 32'h0, 0},
			'{"red", -1, 8'h00, 1, 32'hFF0000FF, 1},
			'{"Red", -1, 8'h00, 1, 32'h0, 0},
			'{"transparent", -1, 8'h00, 1, 32'hFFFFFF00, 1},
			'{"lightgoldenrodyellow", -1, 8'h00, 1, 32'hFAFAD2FF, 1},
			'{"lightgoldenrodyellowx", -1, 8'h00, 1, 32'h0, 0},
			'{"blue", 0, 8'hFF, 1, 32'h0, 0}
		};
		foreach (rows[i]) begin
			s.delete();
			push_text(s, rows[i].s);
			if (rows[i].pos >= 0) s[rows[i].pos] = rows[i].subst;
			queue_string(s, rows[i].typed, rows[i].w, rows[i].v);
		end
		while (char_reqs.size() < RAND_ITEMS) begin
			build_random_string(s);
			queue_string(s, 1'b0, '0, 1'b0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Drive bytes in bursts with random gaps
		burst = 0;
		while (char_reqs.size() > 0) begin
			r = char_reqs.pop_front();
			if (burst == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) :
					$urandom_range(1, 12);
			end
			in_ch.valid <= 1'b1;
			in_ch.data <= {r.last, r.c};
			do @(posedge clk); while (!in_ch.ready);
			parse_color_byte(r.c, r.last, has, res);
			if (has) begin
				if (r.typed) begin
					res.w = r.w;
					res.v = r.v;
				end
				expected_colors.push_back(res);
			end
			burst--;
		end
		in_ch.valid <= 1'b0;

		while (expected_colors.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
